// ===== rtl/core/lpsc_pkg.sv =====
// Shared types and constants for the length-prefix to start-code converter.
package lpsc_pkg;

	localparam int unsigned LEN_W     = 32;
	localparam int unsigned REM_W     = 31;
	localparam logic [2:0]  SIZE_MIN  = 3'd1;
	localparam logic [2:0]  SIZE_MAX  = 3'd4;
	localparam logic [2:0]  SIZE_RST  = 3'd4;

	typedef enum logic [1:0] {
		CMD_START4 = 2'd0,
		CMD_START3 = 2'd1,
		CMD_PAY    = 2'd2,
		CMD_FAIL   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       eob;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_LEN  = 3'b001,
		PH_PAY  = 3'b010,
		PH_DROP = 3'b100
	} phase_t;

endpackage

// ===== rtl/core/lpsc_if.sv =====
// Valid/ready channel interfaces for the input and output byte streams.
interface lpsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_of_buffer;

	modport source (output valid, output in_byte, output last_of_buffer, input ready);
	modport sink (input valid, input in_byte, input last_of_buffer, output ready);
endinterface

interface lpsc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_of_buffer;
	logic       failed;

	modport source (output valid, output out_byte, output end_of_buffer, output failed,
		input ready);
	modport sink (input valid, input out_byte, input end_of_buffer, input failed,
		output ready);
endinterface

// ===== rtl/core/lpsc_front.sv =====
// Front end: parses length prefixes and payload bytes into output commands.
module lpsc_front
	import lpsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	lpsc_in_if.sink    in_chan,
	input  logic       full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [2:0]       cfg_q;
	phase_t           phase_q;
	logic [1:0]       lbs_q;
	logic [LEN_W-1:0] acc_q;
	logic [REM_W-1:0] rem_q;
	logic             first_q;

	logic             acc_en;
	logic [2:0]       size;
	logic [2:0]       seen;
	logic [LEN_W-1:0] len;
	logic [REM_W-1:0] rem_dec;
	logic             last;

	phase_t           phase_d;
	logic [1:0]       lbs_d;
	logic [LEN_W-1:0] acc_d;
	logic [REM_W-1:0] rem_d;
	logic             first_d;

	assign in_chan.ready = !full;
	assign acc_en        = in_chan.valid && in_chan.ready;
	assign last          = in_chan.last_of_buffer;
	assign seen          = {1'b0, lbs_q} + 3'd1;
	assign len           = {acc_q[LEN_W-9:0], in_chan.in_byte};
	assign rem_dec       = rem_q - REM_W'(rem_q != '0);

	always_comb begin
		if (cfg_q < SIZE_MIN) begin
			size = SIZE_MIN;
		end else if (cfg_q > SIZE_MAX) begin
			size = SIZE_MAX;
		end else begin
			size = cfg_q;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		lbs_d         = lbs_q;
		acc_d         = acc_q;
		rem_d         = rem_q;
		first_d       = first_q;
		push          = 1'b0;
		push_cmd.kind = CMD_FAIL;
		push_cmd.data = in_chan.in_byte;
		push_cmd.eob  = 1'b1;
		case (phase_q)
			PH_LEN: begin
				if (seen < size) begin
					if (last) begin
						push = 1'b1;
					end else begin
						acc_d = len;
						lbs_d = seen[1:0];
					end
				end else begin
					acc_d = '0;
					lbs_d = '0;
					if (size == SIZE_MAX && len[LEN_W-1]) begin
						if (last) begin
							push = 1'b1;
						end else begin
							phase_d = PH_DROP;
						end
					end else if (last && len != '0) begin
						push = 1'b1;
					end else begin
						push          = 1'b1;
						push_cmd.kind = first_q ? CMD_START4 : CMD_START3;
						push_cmd.eob  = last;
						first_d       = 1'b0;
						if (!last && len != '0) begin
							rem_d   = len[REM_W-1:0];
							phase_d = PH_PAY;
						end
					end
				end
			end
			PH_PAY: begin
				push = 1'b1;
				if (last) begin
					if (rem_dec == '0) begin
						push_cmd.kind = CMD_PAY;
					end
				end else begin
					push_cmd.kind = CMD_PAY;
					push_cmd.eob  = 1'b0;
					rem_d         = rem_dec;
					if (rem_dec == '0) begin
						phase_d = PH_LEN;
					end
				end
			end
			default: begin
				push = last;
			end
		endcase
		if (last) begin
			phase_d = PH_LEN;
			lbs_d   = '0;
			acc_d   = '0;
			rem_d   = '0;
			first_d = 1'b1;
		end
		push = push && acc_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= SIZE_RST;
			phase_q <= PH_LEN;
			lbs_q   <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			first_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (acc_en) begin
				phase_q <= phase_d;
				lbs_q   <= lbs_d;
				acc_q   <= acc_d;
				rem_q   <= rem_d;
				first_q <= first_d;
			end
		end
	end

	a_pay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> rem_q != '0)
		else $error("payload phase with nothing left to copy");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		acc_en && last |=> phase_q == PH_LEN && first_q && lbs_q == '0)
		else $error("buffer end did not restore the initial parse state");

endmodule

// ===== rtl/core/lpsc_queue.sv =====
// Short command queue between the parsing front end and the output back end.
module lpsc_queue
	import lpsc_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic hd_valid,
	output cmd_t hd_cmd
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full     = count_q == CW'(DEPTH);
	assign hd_valid = count_q != '0;
	assign hd_cmd   = mem_q[rd_ptr_q];
	assign do_pop   = pop && hd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");

endmodule

// ===== rtl/core/lpsc_back.sv =====
// Back end: expands queued commands into output bytes behind an output register.
module lpsc_back
	import lpsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hd_valid,
	input  cmd_t       hd_cmd,
	output logic       pop,
	lpsc_out_if.source out_chan
);

	logic [1:0] step_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       eob_q;
	logic       fail_q;

	logic       adv;
	logic [1:0] step_last;
	logic       at_last;
	logic       is_start;

	assign out_chan.valid         = ov_q;
	assign out_chan.out_byte      = ob_q;
	assign out_chan.end_of_buffer = eob_q;
	assign out_chan.failed        = fail_q;

	always_comb begin
		case (hd_cmd.kind)
			CMD_START4: step_last = 2'd3;
			CMD_START3: step_last = 2'd2;
			default:    step_last = 2'd0;
		endcase
	end

	assign is_start = hd_cmd.kind == CMD_START4 || hd_cmd.kind == CMD_START3;
	assign adv      = hd_valid && (!ov_q || out_chan.ready);
	assign at_last  = step_q == step_last;
	assign pop      = adv && at_last;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_start) begin
				ob_q <= at_last ? 8'd1 : 8'd0;
			end else begin
				ob_q <= (hd_cmd.kind == CMD_PAY) ? hd_cmd.data : 8'd0;
			end
			eob_q  <= at_last && hd_cmd.eob;
			fail_q <= hd_cmd.kind == CMD_FAIL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (adv) begin
				step_q <= at_last ? 2'd0 : step_q + 2'd1;
				ov_q   <= 1'b1;
			end else if (out_chan.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	a_fail_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && fail_q |-> eob_q && ob_q == 8'd0)
		else $error("failure status not marked as end of buffer");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hd_valid && hd_cmd.kind != CMD_START4 |-> step_q != 2'd3)
		else $error("start code step counter ran past the command");

endmodule

// ===== rtl/core/length_prefix_to_start_code.sv =====
// Top level of the length-prefix to start-code converter.
//
//   channel   direction  transaction
//   in_chan   sink       one input byte with its end-of-buffer mark
//   out_chan  source     one framed byte with end-of-buffer and failure flags
//   cfg       write      length prefix size, 1 to 4 bytes
//
// Input bytes are taken one per cycle while the command queue has room, and a
// queued command passes from the queue memory into the output register.
// A payload byte or a status gives one output byte, a start code four or three;
// with input every cycle and a prefix shorter than the start code, the extra
// start-code bytes fill the queue and then stall the input for each further one.
// Reset is asynchronous and active low; the prefix size resets to four bytes.
// Output stalls back up through the queue without losing a transaction.
module length_prefix_to_start_code
	import lpsc_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	lpsc_in_if.sink    in_chan,
	lpsc_out_if.source out_chan,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata
);

	logic full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic hd_valid;
	cmd_t hd_cmd;

	lpsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_chan  (in_chan),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lpsc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.hd_valid(hd_valid),
		.hd_cmd  (hd_cmd)
	);

	lpsc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.hd_valid(hd_valid),
		.hd_cmd  (hd_cmd),
		.pop     (pop),
		.out_chan(out_chan)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the length-prefix to start-code converter with a local framing predictor.
module tb;
	import lpsc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 120;
	localparam int MAX_REPORTS = 60;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eob;
		logic       failed;
	} framed_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_wdata = SIZE_RST;

	lpsc_in_if  in_chan ();
	lpsc_out_if out_chan ();

	length_prefix_to_start_code dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_chan   (in_chan),
		.out_chan  (out_chan),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	in_item_t   bytes_to_send[$];
	framed_t    framed_due[$];
	bit         in_taken;
	int         tx_idle_pct = 25;
	int         rx_idle_pct = 57;
	int         hold_req = 0;
	int         hold_done = 0;
	int         hold_left = 0;
	int         mismatches = 0;
	int         bytes_in = 0;
	int         bytes_out = 0;
	int         buffers_out = 0;
	int         fails_seen = 0;
	int         cycles = 0;

	// Framing predictor state.
	logic [2:0]  prefix_cfg;
	phase_t      conv_phase;
	logic [1:0]  len_seen;
	logic [31:0] len_acc;
	logic [30:0] pay_left;
	logic        first_pending;

	task automatic owe_byte(input logic [7:0] b, input logic eob, input logic failed);
		framed_t item;
		item = '{b, eob, failed};
		framed_due = {framed_due, item};
	endtask

	task automatic close_buffer();
		conv_phase = PH_LEN;
		len_seen = '0;
		len_acc = '0;
		pay_left = '0;
		first_pending = 1'b1;
	endtask

	task automatic fail_buffer();
		owe_byte(8'h00, 1'b1, 1'b1);
		close_buffer();
	endtask

	task automatic convert_byte(input logic [7:0] b, input logic last);
		logic [2:0]  size;
		logic [2:0]  seen;
		logic [31:0] len;
		logic [30:0] rem;
		size = prefix_cfg;
		if (size < SIZE_MIN) size = SIZE_MIN;
		if (size > SIZE_MAX) size = SIZE_MAX;
		case (conv_phase)
			PH_LEN: begin
				seen = {1'b0, len_seen} + 3'd1;
				len = {len_acc[23:0], b};
				if (seen < size) begin
					if (last) begin
						fail_buffer();
					end else begin
						len_acc = len;
						len_seen = seen[1:0];
					end
				end else begin
					len_acc = '0;
					len_seen = '0;
					if (size == SIZE_MAX && len[31]) begin
						if (last) fail_buffer();
						else conv_phase = PH_DROP;
					end else if (last && len != 0) begin
						fail_buffer();
					end else begin
						if (first_pending) owe_byte(8'h00, 1'b0, 1'b0);
						owe_byte(8'h00, 1'b0, 1'b0);
						owe_byte(8'h00, 1'b0, 1'b0);
						owe_byte(8'h01, last, 1'b0);
						first_pending = 1'b0;
						if (last) begin
							close_buffer();
						end else if (len != 0) begin
							pay_left = len[30:0];
							conv_phase = PH_PAY;
						end
					end
				end
			end
			PH_PAY: begin
				rem = pay_left;
				if (rem != 0) rem = rem - 1;
				if (last) begin
					if (rem != 0) begin
						fail_buffer();
					end else begin
						owe_byte(b, 1'b1, 1'b0);
						close_buffer();
					end
				end else begin
					owe_byte(b, 1'b0, 1'b0);
					pay_left = rem;
					if (rem == 0) conv_phase = PH_LEN;
				end
			end
			default: begin
				if (last) fail_buffer();
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s got %0h, wanted %0h", cycles, what, got, want);
		mismatches++;
	endtask

	// Driver: offers the head of the pending queue and holds it until accepted.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_chan.valid <= 1'b0;
		end else if (!in_chan.valid || in_taken) begin
			if (bytes_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_chan.valid <= 1'b1;
				in_chan.in_byte <= bytes_to_send[0].data;
				in_chan.last_of_buffer <= bytes_to_send[0].last;
			end else begin
				in_chan.valid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	// Receiver: random back-pressure, with a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_chan.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			out_chan.ready <= 1'b0;
			hold_done <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Monitor: predicts on each accepted input and checks each output transaction.
	always @(posedge clk) begin
		framed_t want;
		if (arst_n) begin
			if (in_chan.valid && in_chan.ready) begin
				convert_byte(in_chan.in_byte, in_chan.last_of_buffer);
				void'(bytes_to_send.pop_front());
				in_taken = 1'b1;
				bytes_in++;
			end
			if (out_chan.valid && out_chan.ready) begin
				bytes_out++;
				if (out_chan.end_of_buffer === 1'b1) buffers_out++;
				if (out_chan.failed === 1'b1) fails_seen++;
				if (framed_due.size() == 0) begin
					report_mismatch("transaction with nothing due, out_byte", out_chan.out_byte, 0);
				end else begin
					want = framed_due.pop_front();
					if (out_chan.out_byte !== want.data)
						report_mismatch("out_byte", out_chan.out_byte, want.data);
					if (out_chan.end_of_buffer !== want.eob)
						report_mismatch("end_of_buffer", out_chan.end_of_buffer, want.eob);
					if (out_chan.failed !== want.failed)
						report_mismatch("failed", out_chan.failed, want.failed);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d transactions still due", framed_due.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		in_item_t item;
		item = '{b, last};
		bytes_to_send = {bytes_to_send, item};
	endtask

	task automatic queue_prefix(input logic [31:0] len, input int size, input int cut,
		input bit last_at_cut);
		for (int k = 0; k < cut; k++)
			queue_byte(8'(len >> (8 * (size - 1 - k))), last_at_cut && k == cut - 1);
	endtask

	task automatic queue_payload(input int n, input bit last_on_final);
		for (int k = 0; k < n; k++)
			queue_byte(8'($urandom_range(0, 255)), last_on_final && k == n - 1);
	endtask

	function automatic int pick_length();
		if ($urandom_range(99) < 80) return $urandom_range(0, 4);
		return $urandom_range(5, 24);
	endfunction

	task automatic random_buffer(input int size, inout int queued);
		int          kind;
		int          units;
		int          len;
		int          cut;
		int          tail;
		logic [31:0] big;
		int          before_n;
		before_n = bytes_to_send.size();
		kind = $urandom_range(99);
		units = $urandom_range(1, 3);
		for (int u = 0; u < units - 1; u++) begin
			len = pick_length();
			queue_prefix(len, size, size, 1'b0);
			queue_payload(len, 1'b0);
		end
		if (kind < 70) begin
			len = pick_length();
			queue_prefix(len, size, size, len == 0);
			queue_payload(len, 1'b1);
		end else if (kind < 78 && size > 1) begin
			cut = $urandom_range(1, size - 1);
			queue_prefix(pick_length(), size, cut, 1'b1);
		end else if (kind < 86) begin
			len = $urandom_range(1, 6);
			cut = $urandom_range(0, len - 1);
			queue_prefix(len, size, size, cut == 0);
			queue_payload(cut, 1'b1);
		end else if (kind < 93 && size == 4) begin
			big = {1'b1, 31'($urandom)};
			tail = $urandom_range(0, 4);
			queue_prefix(big, 4, 4, tail == 0);
			queue_payload(tail, 1'b1);
		end else begin
			queue_payload($urandom_range(1, 8), 1'b1);
		end
		queued += bytes_to_send.size() - before_n;
	endtask

	task automatic settle();
		while (bytes_to_send.size() != 0 || in_chan.valid || framed_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_prefix_size(input logic [2:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		prefix_cfg = v;
		@(posedge clk);
	endtask

	initial begin
		logic [2:0] sizes[8];
		int         size;
		int         queued;
		sizes = '{3'd1, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd5, 3'd6};
		in_chan.valid = 1'b0;
		in_chan.in_byte = 8'h00;
		in_chan.last_of_buffer = 1'b0;
		out_chan.ready = 1'b0;
		prefix_cfg = SIZE_RST;
		close_buffer();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		write_prefix_size(SIZE_MAX);

		// Four-byte start code, payload, then a zero length closing the buffer.
		queue_prefix(32'd1, 4, 4, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_prefix(32'd0, 4, 4, 1'b1);
		// Top bit set with bytes left to drop, then top bit set on the final byte.
		queue_prefix(32'h8000_0000, 4, 4, 1'b0);
		queue_byte(8'h7F, 1'b1);
		queue_prefix(32'hFFFF_FFFF, 4, 4, 1'b1);
		// Truncated length, and a nonzero length completing on the final byte.
		queue_prefix(32'd0, 4, 2, 1'b1);
		queue_prefix(32'd1, 4, 4, 1'b1);
		settle();

		for (int p = 0; p < 8; p++) begin
			if (p < 3) begin
				tx_idle_pct = 25;
				rx_idle_pct = 57;
			end else if (p < 6) begin
				tx_idle_pct = 57;
				rx_idle_pct = 25;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_prefix_size(sizes[p]);
			size = sizes[p] < SIZE_MIN ? SIZE_MIN : (sizes[p] > SIZE_MAX ? SIZE_MAX : sizes[p]);
			queued = 0;
			while (queued < 31)
				random_buffer(size, queued);
			if (p == 6) hold_req++;
			settle();
		end

		$display("covered %0d input bytes at prefix settings 0 to 7", bytes_in);
		$display("with %0d framed transactions over %0d buffers, %0d of them flagged malformed",
			bytes_out, buffers_out, fails_seen);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/lpsc_pkg.sv
rtl/core/lpsc_if.sv
rtl/core/lpsc_front.sv
rtl/core/lpsc_queue.sv
rtl/core/lpsc_back.sv
rtl/core/length_prefix_to_start_code.sv
tb/tb.sv
